// ===== src/tla_pkg.sv =====
// tla_pkg: shared types and constants of the text line annotator
// character codes, register indexes, queue entry and config structs
// no dependencies
package tla_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int SEQ_LEN       = NUMBER_DIGITS + 3;
  localparam int POS_W         = $clog2(SEQ_LEN);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MARK_ENDS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TAB        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_CONTROL    = 3'd5;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;
  localparam logic [3:0] DIGIT_HIGH  = 4'h3;

  localparam logic [1:0] RUN_MAX     = 2'd3;
  localparam logic [1:0] RUN_SQUEEZE = 2'd3;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic mark_ends;
    logic squeeze_blank;
    logic show_tab;
    logic show_control;
  } cfg_t;

  // one accepted byte, fully classified: optional number prefix, one or two tail bytes
  typedef struct packed {
    logic                            num;
    logic [NUMBER_DIGITS-1:0][7:0]   num_bytes;
    logic [7:0]                      tail0;
    logic [7:0]                      tail1;
    logic                            two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/tla_in_if.sv =====
// tla_in_if: input channel of the text line annotator
// depends on nothing
interface tla_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       file_start;

  modport source (output valid, output text_byte, output file_start, input ready);
  modport sink   (input valid, input text_byte, input file_start, output ready);
endinterface

// ===== src/tla_out_if.sv =====
// tla_out_if: result channel of the text line annotator
// depends on nothing
interface tla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== src/tla_cfg_if.sv =====
// tla_cfg_if: register write channel of the text line annotator
// depends on tla_pkg for field widths
interface tla_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tla_pkg::CFG_INDEX_W-1:0] index;
  logic [tla_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/tla_front.sv =====
// tla_front: accepts text bytes, keeps the line state and classifies each byte
// into a queue entry; depends on tla_pkg and tla_in_if
module tla_front (
  input  logic                clk,
  input  logic                rst_n,
  tla_in_if.sink              in_ch,
  input  tla_pkg::cfg_t       cfg,
  input  tla_pkg::q_status_t  q_status,
  output logic                push,
  output tla_pkg::entry_t     push_entry
);

  tla_pkg::bcd_t cnt_r, cnt_nxt;
  logic [1:0]    run_r, run_nxt;
  logic          als_r, als_nxt;

  tla_pkg::bcd_t cnt_cur, cnt_inc;
  logic [1:0]    run_cur, run_nl;
  logic          als_cur;
  logic          accept, is_nl, squeeze, all_nines, carry, seen;
  logic [7:0]    c;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.text_byte;

  always_comb begin
    // a new file restarts numbering before its first byte is handled
    if (in_ch.file_start) begin
      cnt_cur = '0;
      cnt_cur[tla_pkg::NUMBER_DIGITS-1] = 4'd1;
      run_cur = 2'd0;
      als_cur = 1'b1;
    end else begin
      cnt_cur = cnt_r;
      run_cur = run_r;
      als_cur = als_r;
    end

    all_nines = 1'b1;
    for (int i = 0; i < tla_pkg::NUMBER_DIGITS; i++) begin
      if (cnt_cur[i] != 4'd9) all_nines = 1'b0;
    end
    cnt_inc = cnt_cur;
    carry   = 1'b1;
    for (int i = tla_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (carry) begin
        if (cnt_inc[i] == 4'd9) begin
          cnt_inc[i] = 4'd0;
        end else begin
          cnt_inc[i] = cnt_inc[i] + 4'd1;
          carry      = 1'b0;
        end
      end
    end

    // leading zeros show as spaces, the last digit always shows
    seen = 1'b0;
    for (int i = 0; i < tla_pkg::NUMBER_DIGITS; i++) begin
      if (cnt_cur[i] != 4'd0 || seen || i == tla_pkg::NUMBER_DIGITS - 1) begin
        seen = 1'b1;
        push_entry.num_bytes[i] = {tla_pkg::DIGIT_HIGH, cnt_cur[i]};
      end else begin
        push_entry.num_bytes[i] = tla_pkg::CH_SPACE;
      end
    end

    is_nl   = (c == tla_pkg::CH_NL);
    run_nl  = (run_cur == tla_pkg::RUN_MAX) ? tla_pkg::RUN_MAX : run_cur + 2'd1;
    squeeze = is_nl && cfg.squeeze_blank && (run_nl == tla_pkg::RUN_SQUEEZE);

    push_entry.tail0 = c;
    push_entry.tail1 = c;
    push_entry.two   = 1'b0;
    if (is_nl) begin
      push_entry.num = als_cur && cfg.number_all && !cfg.number_nonblank;
      run_nxt        = run_nl;
      als_nxt        = squeeze ? als_cur : 1'b1;
      if (cfg.mark_ends) begin
        push_entry.tail0 = tla_pkg::CH_DOLLAR;
        push_entry.two   = 1'b1;
      end
    end else begin
      push_entry.num = als_cur && (cfg.number_all || cfg.number_nonblank);
      run_nxt        = 2'd0;
      als_nxt        = 1'b0;
      if (cfg.show_tab && c == tla_pkg::CH_TAB) begin
        push_entry.tail0 = tla_pkg::CH_CARET;
        push_entry.tail1 = tla_pkg::CH_I;
        push_entry.two   = 1'b1;
      end else if (cfg.show_control && c == tla_pkg::CH_DEL) begin
        push_entry.tail0 = tla_pkg::CH_CARET;
        push_entry.tail1 = tla_pkg::CH_QMARK;
        push_entry.two   = 1'b1;
      end else if (cfg.show_control && c < tla_pkg::CTRL_LIMIT && c != tla_pkg::CH_TAB) begin
        push_entry.tail0 = tla_pkg::CH_CARET;
        push_entry.tail1 = c + tla_pkg::CTRL_OFFSET;
        push_entry.two   = 1'b1;
      end
    end

    cnt_nxt = (push_entry.num && !squeeze && !all_nines) ? cnt_inc : cnt_cur;
    push    = accept && !squeeze;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cnt_r[tla_pkg::NUMBER_DIGITS-1] <= 4'd1;
      run_r <= 2'd0;
      als_r <= 1'b1;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
      als_r <= als_nxt;
    end
  end

endmodule

// ===== src/tla_queue.sv =====
// tla_queue: short entry queue between front and back
// depends on tla_pkg
module tla_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tla_pkg::entry_t     push_entry,
  input  logic                pop,
  output tla_pkg::entry_t     head,
  output tla_pkg::q_status_t  status
);

  tla_pkg::entry_t                   mem_r [tla_pkg::QUEUE_DEPTH];
  logic [tla_pkg::QPTR_W-1:0]        wr_r, rd_r;
  logic [tla_pkg::QCNT_W-1:0]        cnt_r;

  assign head         = mem_r[rd_r];
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == tla_pkg::QCNT_W'(tla_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == tla_pkg::QPTR_W'(tla_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == tla_pkg::QPTR_W'(tla_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== src/tla_back.sv =====
// tla_back: walks the head entry byte by byte into the output register
// depends on tla_pkg and tla_out_if
module tla_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tla_pkg::entry_t     head,
  input  tla_pkg::q_status_t  q_status,
  output logic                pop,
  tla_out_if.source           out_ch
);

  logic [tla_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      mid_r, mid_nxt;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r;

  logic [tla_pkg::POS_W-1:0] start, stop, cur;
  logic [tla_pkg::SEQ_LEN-1:0][7:0] seq;
  logic [7:0]                sel;
  logic                      load, last;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    // byte list: digits, tab, then one or two tail bytes
    for (int i = 0; i < tla_pkg::NUMBER_DIGITS; i++) seq[i] = head.num_bytes[i];
    seq[tla_pkg::NUMBER_DIGITS]     = tla_pkg::CH_TAB;
    seq[tla_pkg::NUMBER_DIGITS + 1] = head.tail0;
    seq[tla_pkg::NUMBER_DIGITS + 2] = head.tail1;

    start = head.num ? '0 : tla_pkg::POS_W'(tla_pkg::NUMBER_DIGITS + 1);
    stop  = head.two ? tla_pkg::POS_W'(tla_pkg::NUMBER_DIGITS + 2)
                     : tla_pkg::POS_W'(tla_pkg::NUMBER_DIGITS + 1);
    cur   = mid_r ? pos_r : start;

    sel = '0;
    for (int i = 0; i < tla_pkg::SEQ_LEN; i++) begin
      if (cur == tla_pkg::POS_W'(i)) sel = seq[i];
    end

    last    = (cur == stop);
    load    = !q_status.empty && (!out_valid_r || out_ch.ready);
    pop     = load && last;
    pos_nxt = cur + 1'b1;
    mid_nxt = load ? !last : mid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
      if (load) pos_r <= pos_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel;
      out_last_r <= last;
    end
  end

endmodule

// ===== src/text_line_annotator.sv =====
// text_line_annotator: cat-style output filter with optional line numbering
// in_ch takes one text byte per beat with a file_start flag; out_ch gives
// the formatted bytes, last_of_run marking the final byte caused by an input.
// cfg_ch writes one 1-bit register per beat (bit 0 of data); index order:
// number_all, number_nonblank, mark_ends, squeeze_blank, show_tab,
// show_control. Unused indexes are ignored. cfg_ch is always ready; write
// only while the block is idle.
// With the queue empty and the output register free, the first result byte
// of an input goes through a queue entry and then the output register.
// Throughput: one output byte per cycle while the receiver is ready; an
// input causes k bytes (0 to 9) and occupies the back end for all of them,
// so plain text runs at one byte per cycle and a numbered line start gives
// eight or nine bytes. The rate is set by the single output byte per cycle
// of the back end; a two-entry queue lets the front keep accepting while
// the back expands. Reset (synchronous, rst_n low): config cleared, line
// count 1, at line start, queue and output empty; data registers not reset.
// Receiver stall: the output register holds its byte, the queue fills and
// in_ch.ready drops; nothing is lost.
// Depends on tla_pkg, the three channel interfaces, front, queue and back.
module text_line_annotator (
  input  logic       clk,
  input  logic       rst_n,
  tla_in_if.sink     in_ch,
  tla_out_if.source  out_ch,
  tla_cfg_if.sink    cfg_ch
);

  tla_pkg::cfg_t      cfg_r;
  tla_pkg::entry_t    push_entry, head;
  tla_pkg::q_status_t q_status;
  logic               push, pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tla_pkg::REG_NUMBER_ALL:      cfg_r.number_all      <= cfg_ch.data[0];
        tla_pkg::REG_NUMBER_NONBLANK: cfg_r.number_nonblank <= cfg_ch.data[0];
        tla_pkg::REG_MARK_ENDS:       cfg_r.mark_ends       <= cfg_ch.data[0];
        tla_pkg::REG_SQUEEZE_BLANK:   cfg_r.squeeze_blank   <= cfg_ch.data[0];
        tla_pkg::REG_SHOW_TAB:        cfg_r.show_tab        <= cfg_ch.data[0];
        tla_pkg::REG_SHOW_CONTROL:    cfg_r.show_control    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  tla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  tla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  tla_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  // only a newline can be dropped
  a_non_nl_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.text_byte != tla_pkg::CH_NL) |-> push)
    else $error("non-newline beat produced no queue entry");

  // an expansion continues without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("gap inside an output run");

  // queued work reaches a free output register
  a_back_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_status.empty && (!out_ch.valid || out_ch.ready)) |=> out_ch.valid)
    else $error("back end idle with queued work");

  // the front stalls only on a full queue
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ch.ready) |-> (q_status.full && !q_status.empty))
    else $error("input stalled without a full queue");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for text_line_annotator, the cat-style byte filter
// predicts every formatted byte from the raw text and the register settings
// depends on tla_pkg, tla_in_if, tla_out_if, tla_cfg_if and the top level
module tb;

  localparam int         MAX_GAP        = 40;
  localparam int         DRAIN_CYCLES   = 16;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         MAX_REPORTS    = 40;
  localparam int         PHASE_BEATS    = 22;
  localparam int         COUNT_LIMIT    = 10 ** tla_pkg::NUMBER_DIGITS - 1;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_LOWER_A     = 8'h61;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } formatted_byte_t;

  logic clk;
  logic rst_n;

  tla_in_if  in_ch ();
  tla_out_if out_ch ();
  tla_cfg_if cfg_ch ();

  text_line_annotator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block's line state and registers
  logic [19:0]   line_no;
  logic [1:0]    nl_run;
  logic          line_start;
  tla_pkg::cfg_t shadow_cfg;

  formatted_byte_t expected_bytes[$];

  int error_count     = 0;
  int text_beats      = 0;
  int bytes_checked   = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.text_byte    = '0;
    in_ch.file_start   = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at byte %0d: %s got %0h expected %0h", bytes_checked, what, got, want);
  endtask

  function automatic void push_expected(input logic [7:0] b);
    expected_bytes.push_back('{out_byte: b, last_of_run: 1'b0});
  endfunction

  function automatic void push_line_number();
    int v;
    int digit[tla_pkg::NUMBER_DIGITS];
    bit shown;
    v = int'(line_no);
    shown = 1'b0;
    for (int i = tla_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
      digit[i] = v % 10;
      v = v / 10;
    end
    // leading zeros become spaces, the units digit always shows
    for (int i = 0; i < tla_pkg::NUMBER_DIGITS; i++) begin
      if (digit[i] != 0 || shown || i == tla_pkg::NUMBER_DIGITS - 1) begin
        shown = 1'b1;
        push_expected(CH_ZERO + 8'(digit[i]));
      end else begin
        push_expected(tla_pkg::CH_SPACE);
      end
    end
    push_expected(tla_pkg::CH_TAB);
    if (int'(line_no) < COUNT_LIMIT) line_no = line_no + 20'd1;
  endfunction

  // expected formatted bytes for one accepted text beat
  function automatic void predict_formatted(input logic [7:0] c, input logic fs);
    int first;
    logic [1:0] run;
    first = expected_bytes.size();
    if (fs) begin
      line_no    = 20'd1;
      nl_run     = 2'd0;
      line_start = 1'b1;
    end
    if (c == tla_pkg::CH_NL) begin
      run = (nl_run < tla_pkg::RUN_MAX) ? nl_run + 2'd1 : tla_pkg::RUN_MAX;
      nl_run = run;
      // squeezed newline: nothing out, line start kept
      if (shadow_cfg.squeeze_blank && run >= tla_pkg::RUN_SQUEEZE) return;
      if (line_start && shadow_cfg.number_all && !shadow_cfg.number_nonblank)
        push_line_number();
      if (shadow_cfg.mark_ends) push_expected(tla_pkg::CH_DOLLAR);
      push_expected(tla_pkg::CH_NL);
      line_start = 1'b1;
    end else begin
      if (line_start && (shadow_cfg.number_all || shadow_cfg.number_nonblank))
        push_line_number();
      line_start = 1'b0;
      nl_run = 2'd0;
      if (shadow_cfg.show_tab && c == tla_pkg::CH_TAB) begin
        push_expected(tla_pkg::CH_CARET);
        push_expected(tla_pkg::CH_I);
      end else if (shadow_cfg.show_control && c == tla_pkg::CH_DEL) begin
        push_expected(tla_pkg::CH_CARET);
        push_expected(tla_pkg::CH_QMARK);
      end else if (shadow_cfg.show_control && c < tla_pkg::CTRL_LIMIT &&
                   c != tla_pkg::CH_TAB) begin
        push_expected(tla_pkg::CH_CARET);
        push_expected(c + tla_pkg::CTRL_OFFSET);
      end else begin
        push_expected(c);
      end
    end
    if (expected_bytes.size() > first)
      expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
  endfunction

  // beat monitor: text beats, register writes and formatted bytes
  always @(posedge clk) begin
    formatted_byte_t want;
    if (!rst_n) begin
      line_no    = 20'd1;
      nl_run     = 2'd0;
      line_start = 1'b1;
      shadow_cfg = '0;
    end else begin
      // a text beat sees the registers as they were before this edge
      if (in_ch.valid && in_ch.ready) begin
        text_beats++;
        predict_formatted(in_ch.text_byte, in_ch.file_start);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tla_pkg::REG_NUMBER_ALL:      shadow_cfg.number_all      = cfg_ch.data[0];
          tla_pkg::REG_NUMBER_NONBLANK: shadow_cfg.number_nonblank = cfg_ch.data[0];
          tla_pkg::REG_MARK_ENDS:       shadow_cfg.mark_ends       = cfg_ch.data[0];
          tla_pkg::REG_SQUEEZE_BLANK:   shadow_cfg.squeeze_blank   = cfg_ch.data[0];
          tla_pkg::REG_SHOW_TAB:        shadow_cfg.show_tab        = cfg_ch.data[0];
          tla_pkg::REG_SHOW_CONTROL:    shadow_cfg.show_control    = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_ch.out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
          if (out_ch.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_ch.last_of_run, want.last_of_run);
        end
        bytes_checked++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes still expected",
               quiet_cycles, expected_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_text_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.text_byte  <= b;
    in_ch.file_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and let the block empty, squeezed bytes included
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tla_pkg::CFG_INDEX_W-1:0] idx,
                           input logic bit_value);
    logic [tla_pkg::CFG_DATA_W-1:0] value;
    value    = tla_pkg::CFG_DATA_W'($urandom);
    value[0] = bit_value;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_config(input tla_pkg::cfg_t c);
    wait_drained();
    write_reg(tla_pkg::REG_NUMBER_ALL, c.number_all);
    write_reg(tla_pkg::REG_NUMBER_NONBLANK, c.number_nonblank);
    write_reg(tla_pkg::REG_MARK_ENDS, c.mark_ends);
    write_reg(tla_pkg::REG_SQUEEZE_BLANK, c.squeeze_blank);
    write_reg(tla_pkg::REG_SHOW_TAB, c.show_tab);
    write_reg(tla_pkg::REG_SHOW_CONTROL, c.show_control);
    // an index past the last register must change nothing
    write_reg(tla_pkg::REG_SHOW_CONTROL + tla_pkg::CFG_INDEX_W'($urandom_range(2, 1)),
              1'($urandom));
  endtask

  function automatic logic [7:0] random_text_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)      return 8'($urandom_range(8'h7E, tla_pkg::CH_SPACE));
    else if (pick < 65) return tla_pkg::CH_TAB;
    else if (pick < 75) return 8'($urandom_range(tla_pkg::CTRL_LIMIT - 1, 0));
    else if (pick < 80) return tla_pkg::CH_DEL;
    else                return 8'($urandom_range(255, 128));
  endfunction

  task automatic send_random_line();
    logic fs;
    int len;
    int blank_run;
    fs = ($urandom_range(99) < 10);
    len = $urandom_range(5, 0);
    repeat (len) begin
      send_text_byte(random_text_char(), fs);
      fs = 1'b0;
    end
    blank_run = ($urandom_range(99) < 20) ? $urandom_range(4, 2) : 1;
    repeat (blank_run) begin
      send_text_byte(tla_pkg::CH_NL, fs);
      fs = 1'b0;
    end
  endtask

  // reset values: everything passes through untouched
  task automatic test_plain_passthrough();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(CH_LOWER_A, 1'b0);
    send_text_byte(tla_pkg::CH_TAB, 1'b0);
    send_text_byte(tla_pkg::CH_DEL, 1'b0);
    send_text_byte(8'h1B, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_caret_forms();
    tla_pkg::cfg_t c;
    c = '0;
    c.show_tab = 1'b1;
    c.show_control = 1'b1;
    c.mark_ends = 1'b1;
    apply_config(c);
    send_text_byte(tla_pkg::CH_TAB, 1'b0);
    send_text_byte(tla_pkg::CH_DEL, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(tla_pkg::CTRL_LIMIT - 1, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
    // tab stays raw without show_tab even with control display on
    c.show_tab = 1'b0;
    apply_config(c);
    send_text_byte(tla_pkg::CH_TAB, 1'b0);
    send_text_byte(tla_pkg::CH_DEL, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_numbering_modes();
    tla_pkg::cfg_t c;
    c = '0;
    c.number_all = 1'b1;
    c.squeeze_blank = 1'b1;
    apply_config(c);
    // leading blank lines of a file, the third one squeezed and unnumbered
    send_text_byte(tla_pkg::CH_NL, 1'b1);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
    send_text_byte(CH_LOWER_A, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
    // nonblank numbering wins over numbering every line
    c.number_nonblank = 1'b1;
    c.squeeze_blank = 1'b0;
    apply_config(c);
    send_text_byte(tla_pkg::CH_NL, 1'b1);
    send_text_byte(CH_LOWER_A + 8'd1, 1'b0);
    send_text_byte(tla_pkg::CH_NL, 1'b0);
  endtask

  // enough numbered blank lines for the count to reach two digits
  task automatic test_counter_digits();
    tla_pkg::cfg_t c;
    c = '0;
    c.number_all = 1'b1;
    apply_config(c);
    send_text_byte(tla_pkg::CH_NL, 1'b1);
    repeat (11) send_text_byte(tla_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_receiver_hold_off();
    tla_pkg::cfg_t c;
    c = '0;
    c.number_nonblank = 1'b1;
    c.mark_ends = 1'b1;
    apply_config(c);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (6) send_random_line();
  endtask

  task automatic test_random_traffic();
    int idle_mix[4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{14, 14}};
    tla_pkg::cfg_t c;
    int sent_before;
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        if (m == 0 && p == 0)      c = '0;
        else if (m == 1 && p == 0) c = '1;
        else                       c = tla_pkg::cfg_t'(6'($urandom));
        apply_config(c);
        sender_idle_pct = idle_mix[m][0];
        recv_stall_pct  = idle_mix[m][1];
        sent_before = text_beats;
        while (text_beats - sent_before < PHASE_BEATS) begin
          if ($urandom_range(99) < 10)
            send_text_byte(8'($urandom), ($urandom_range(99) < 20));
          else
            send_random_line();
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_plain_passthrough();
    test_caret_forms();
    test_numbering_modes();
    test_counter_digits();
    test_receiver_hold_off();
    test_random_traffic();
    wait_drained();
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never delivered", 0, expected_bytes.size());
    $display("%0d text beats in, %0d formatted bytes checked, %0d mismatches",
             text_beats, bytes_checked, error_count);
    $display("ran caret forms, both numbering modes, squeezing, two-digit counts, a long");
    $display("receiver hold-off and random lines under four idling mixes");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tla_pkg.sv
src/tla_in_if.sv
src/tla_out_if.sv
src/tla_cfg_if.sv
src/tla_front.sv
src/tla_queue.sv
src/tla_back.sv
src/text_line_annotator.sv
verif/tb.sv
